### rtl/core/btpg_pkg.sv
// ----------------------------------------------------------------------------
// btpg_pkg
// Shared types, codes and the 5x7 font ROM of the bitmap text pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package btpg_pkg;

    // Fixed field widths of the command beat
    localparam int X_W         = 7;
    localparam int Y_W         = 5;

    localparam int HEADER_BYTES = 8;
    localparam int GLYPH_ROWS   = 7;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_LABEL_LEN    = 2'd0;
    localparam logic [1:0] REG_BACK_COLOR   = 2'd1;
    localparam logic [1:0] REG_FG_COLOR     = 2'd2;
    localparam logic [1:0] REG_BUFFER_BYTES = 2'd3;

    typedef struct packed {
        logic            found;
        logic [0:6][4:0] rows;   // rows[0] is the top row, bit 4 the left column
    } t_glyph;

    // One glyph probe: which row, which bit of the row
    typedef struct packed {
        logic       en;
        logic [2:0] row;
        logic [2:0] bit_idx;
    } t_tap;

    function automatic t_glyph font_glyph(input logic [7:0] code);
        t_glyph g;
        g.found = 1'b1;
        g.rows  = '0;
        case (code)
            "A": g.rows = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h00};
            "C": g.rows = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
            "D": g.rows = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E": g.rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "H": g.rows = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I": g.rows = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "K": g.rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "M": g.rows = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h00};
            "N": g.rows = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h00};
            "O": g.rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P": g.rows = {5'h1F, 5'h11, 5'h11, 5'h1F, 5'h10, 5'h10, 5'h10};
            "R": g.rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S": g.rows = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T": g.rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g.rows = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "W": g.rows = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
            "a": g.rows = {5'h00, 5'h00, 5'h0E, 5'h01, 5'h0F, 5'h11, 5'h0F};
            "c": g.rows = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h10, 5'h11, 5'h0E};
            "d": g.rows = {5'h00, 5'h00, 5'h01, 5'h0F, 5'h11, 5'h11, 5'h0F};
            "e": g.rows = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
            "h": g.rows = {5'h10, 5'h10, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
            "i": g.rows = {5'h04, 5'h00, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h0E};
            "k": g.rows = {5'h10, 5'h10, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12};
            "m": g.rows = {5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h11, 5'h00};
            "n": g.rows = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
            "o": g.rows = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            "p": g.rows = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10};
            "r": g.rows = {5'h00, 5'h00, 5'h16, 5'h19, 5'h10, 5'h10, 5'h10};
            "s": g.rows = {5'h00, 5'h00, 5'h0E, 5'h10, 5'h0E, 5'h01, 5'h1E};
            "t": g.rows = {5'h04, 5'h04, 5'h0E, 5'h04, 5'h04, 5'h04, 5'h06};
            "u": g.rows = {5'h00, 5'h00, 5'h11, 5'h11, 5'h11, 5'h13, 5'h0D};
            "w": g.rows = {5'h00, 5'h00, 5'h11, 5'h11, 5'h15, 5'h15, 5'h0A};
            default: g.found = 1'b0;
        endcase
        return g;
    endfunction

endpackage

`default_nettype wire

### rtl/core/btpg_glyph_tap.sv
// ----------------------------------------------------------------------------
// btpg_glyph_tap
// Font ROM lookup of one character code and test of one glyph bit.
// ----------------------------------------------------------------------------
`default_nettype none

module btpg_glyph_tap (
    input  wire logic [7:0]      i_code,
    input  wire btpg_pkg::t_tap  i_tap,
    output logic                 o_hit
);

    btpg_pkg::t_glyph glyph;
    logic [7:0]       row_bits;

    always_comb begin
        glyph    = btpg_pkg::font_glyph(i_code);
        row_bits = '0;
        if (32'(i_tap.row) < btpg_pkg::GLYPH_ROWS) begin
            row_bits = {3'b000, glyph.rows[i_tap.row]};
        end
        // bit indexes past the 5-column font read as zero
        o_hit = i_tap.en & glyph.found & row_bits[i_tap.bit_idx];
    end

endmodule

`default_nettype wire

### rtl/core/bitmap_text_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// bitmap_text_pixel_generator_core
// Text label renderer: a label store of character codes plus a 5x7 font ROM,
// answering pixel color queries of the rendered label image.
// ----------------------------------------------------------------------------
// Every command beat (start high while busy is low) runs as follows: at the
// accept the label store is read into registers (synchronous read) along
// with the decoded beat, then the result is registered and presented on
// the o_ result ports with o_valid high for exactly one cycle. busy is high
// in the cycle after each accept; a new beat is not taken while busy,
// but it can be taken in the cycle in which the previous result is shown.
// The receiver cannot stall: sample the result ports whenever o_valid is high.
// A write beat (i_cmd = 0) stores i_char_code at i_char_slot (slots at or
// above MAX_CHARS are ignored) and returns color 0, not inside. A read beat
// (i_cmd = 1) returns the color of (i_pixel_x, i_pixel_y). Every result also
// carries the label width (low 7 bits) and whether header plus image fits
// buffer_bytes. Label slots below label_len must be written before reads.
// Registers: 0x0 label_len, 0x4 background color, 0x8 fg_color,
// 0xC buffer_bytes.
// Change them only while no beat is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_text_pixel_generator_core #(
    parameter int MAX_CHARS    = 16,
    parameter int CELL_WIDTH   = 6,
    parameter int CELL_GAP     = 1,
    parameter int IMAGE_HEIGHT = 16,
    parameter int GLYPH_WIDTH  = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // command beat
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [3:0]  i_char_slot,
    input  wire logic [7:0]  i_char_code,
    input  wire logic [6:0]  i_pixel_x,
    input  wire logic [4:0]  i_pixel_y,

    // result beat
    output logic             o_valid,
    output logic [15:0]      o_pixel_color,
    output logic             o_inside_res,
    output logic [6:0]       o_image_width,
    output logic             o_fits,

    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW     = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int NW     = $clog2(MAX_CHARS + 1);
    // a gap wider than the cell makes the width wrap, so keep the full word then
    localparam int WW     = (CELL_WIDTH >= CELL_GAP) ?
                            $clog2(MAX_CHARS * CELL_WIDTH + 1) : 32;
    localparam int NDW    = (CELL_WIDTH >= CELL_GAP) ?
                            $clog2(btpg_pkg::HEADER_BYTES +
                                   MAX_CHARS * CELL_WIDTH * IMAGE_HEIGHT * 2 + 1) : 32;
    localparam int CMPW   = (NDW > 16) ? NDW : 16;
    localparam int XCOLS  = 1 << btpg_pkg::X_W;
    localparam int QW     = $clog2((XCOLS - 1) / CELL_WIDTH + 1);
    localparam int RW     = (CELL_WIDTH > 1) ? $clog2(CELL_WIDTH) : 1;
    localparam int TOP    = (IMAGE_HEIGHT - btpg_pkg::GLYPH_ROWS) / 2;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [4:0]  r_label_len;
    logic [15:0] r_back_color;
    logic [15:0] r_fg_color;
    logic [15:0] r_buffer_bytes;
    logic        cfg_wr;

    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label_len    <= '0;
            r_back_color   <= '0;
            r_fg_color     <= 16'hFFFF;
            r_buffer_bytes <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                btpg_pkg::REG_LABEL_LEN:    r_label_len    <= pwdata[4:0];
                btpg_pkg::REG_BACK_COLOR:   r_back_color   <= pwdata[15:0];
                btpg_pkg::REG_FG_COLOR:     r_fg_color     <= pwdata[15:0];
                btpg_pkg::REG_BUFFER_BYTES: r_buffer_bytes <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            btpg_pkg::REG_LABEL_LEN:    prdata = 32'(r_label_len);
            btpg_pkg::REG_BACK_COLOR:   prdata = 32'(r_back_color);
            btpg_pkg::REG_FG_COLOR:     prdata = 32'(r_fg_color);
            btpg_pkg::REG_BUFFER_BYTES: prdata = 32'(r_buffer_bytes);
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Label geometry
    // ------------------------------------------------------------------
    logic [NW-1:0] act_len;
    logic [WW-1:0] img_w;

    always_comb begin
        // lengths past the store depth are clamped
        if (32'(r_label_len) > 32'(MAX_CHARS)) begin
            act_len = NW'(MAX_CHARS);
        end else begin
            act_len = NW'(r_label_len);
        end
        if (act_len == '0) begin
            img_w = '0;
        end else begin
            img_w = WW'(WW'(act_len) * WW'(CELL_WIDTH) - WW'(CELL_GAP));
        end
    end

    // x / CELL_WIDTH and x % CELL_WIDTH as constant tables
    logic [QW-1:0] quo_tbl [XCOLS];
    logic [RW-1:0] rem_tbl [XCOLS];

    for (genvar gx = 0; gx < XCOLS; gx++) begin : g_div
        assign quo_tbl[gx] = QW'(gx / CELL_WIDTH);
        assign rem_tbl[gx] = RW'(gx % CELL_WIDTH);
    end

    // ------------------------------------------------------------------
    // Accept stage: decode the beat, pick the (up to two) cells whose
    // glyph can cover column x, and launch the label store reads.
    // ------------------------------------------------------------------
    logic            accept;
    logic            r_busy;
    logic [QW-1:0]   cell_q;
    logic [RW-1:0]   cell_r;
    logic            row_ok;
    logic [2:0]      glyph_row;
    logic            is_read;
    btpg_pkg::t_tap  tap0;
    btpg_pkg::t_tap  tap1;
    logic [AW-1:0]   rd_addr0;
    logic [AW-1:0]   rd_addr1;
    logic            wr_en;
    logic            n_inside;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    always_comb begin
        is_read   = (i_cmd == btpg_pkg::CMD_READ);
        cell_q    = quo_tbl[i_pixel_x];
        cell_r    = rem_tbl[i_pixel_x];
        row_ok    = (32'(i_pixel_y) >= 32'(TOP)) &&
                    (32'(i_pixel_y) < 32'(TOP + btpg_pkg::GLYPH_ROWS));
        glyph_row = row_ok ? 3'(32'(i_pixel_y) - 32'(TOP)) : '0;

        // cell q: column x sits at offset r inside it
        tap0.en      = is_read && row_ok && (32'(cell_q) < 32'(act_len)) &&
                       (32'(cell_r) < 32'(GLYPH_WIDTH));
        tap0.row     = glyph_row;
        tap0.bit_idx = tap0.en ? 3'(32'(GLYPH_WIDTH - 1) - 32'(cell_r)) : '0;

        // cell q-1: only reached when glyphs are wider than the cell
        tap1.en      = is_read && row_ok && (cell_q != '0) &&
                       (32'(cell_q) - 32'd1 < 32'(act_len)) &&
                       (32'(cell_r) + 32'(CELL_WIDTH) < 32'(GLYPH_WIDTH));
        tap1.row     = glyph_row;
        tap1.bit_idx = tap1.en ?
                       3'(32'(GLYPH_WIDTH - 1 - CELL_WIDTH) - 32'(cell_r)) : '0;

        rd_addr0 = tap0.en ? AW'(cell_q) : '0;
        rd_addr1 = tap1.en ? AW'(cell_q - 1'b1) : '0;

        wr_en    = (i_cmd == btpg_pkg::CMD_WRITE) &&
                   (32'(i_char_slot) < 32'(MAX_CHARS));
        n_inside = is_read && (32'(i_pixel_x) < 32'(img_w)) &&
                   (32'(i_pixel_y) < 32'(IMAGE_HEIGHT));
    end

    // Label store: one write port, two registered read ports. Only one beat
    // is in flight, so a write and a dependent read never overlap.
    logic [7:0] r_label_mem [MAX_CHARS];
    logic [7:0] r_code0;
    logic [7:0] r_code1;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (wr_en) begin
                r_label_mem[AW'(i_char_slot)] <= i_char_code;
            end
            r_code0 <= r_label_mem[rd_addr0];
            r_code1 <= r_label_mem[rd_addr1];
        end
    end

    // stage payload
    logic           r_inside;
    logic [WW-1:0]  r_w;
    btpg_pkg::t_tap r_tap0;
    btpg_pkg::t_tap r_tap1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_inside <= n_inside;
            r_w      <= img_w;
            r_tap0   <= tap0;
            r_tap1   <= tap1;
        end
    end

    // ------------------------------------------------------------------
    // Glyph stage: font lookup of both candidate codes, color select,
    // buffer size check.
    // ------------------------------------------------------------------
    logic            hit0;
    logic            hit1;
    logic [NDW-1:0]  need;
    logic [15:0]     n_color;
    logic            n_fits;

    btpg_glyph_tap u_tap0 (
        .i_code (r_code0),
        .i_tap  (r_tap0),
        .o_hit  (hit0)
    );

    btpg_glyph_tap u_tap1 (
        .i_code (r_code1),
        .i_tap  (r_tap1),
        .o_hit  (hit1)
    );

    always_comb begin
        n_color = '0;
        if (r_inside) begin
            n_color = (hit0 | hit1) ? r_fg_color : r_back_color;
        end
        need   = NDW'(btpg_pkg::HEADER_BYTES) + NDW'(r_w) * NDW'(2 * IMAGE_HEIGHT);
        n_fits = (r_w != '0) && (CMPW'(need) <= CMPW'(r_buffer_bytes));
    end

    // result register
    logic        r_valid;
    logic [15:0] r_out_color;
    logic        r_out_inside;
    logic [6:0]  r_out_width;
    logic        r_out_fits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_out_color  <= n_color;
            r_out_inside <= r_inside;
            r_out_width  <= 7'(r_w);
            r_out_fits   <= n_fits;
        end
    end

    assign o_valid       = r_valid;
    assign o_pixel_color = r_out_color;
    assign o_inside_res  = r_out_inside;
    assign o_image_width = r_out_width;
    assign o_fits        = r_out_fits;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_valid)
        else $error("accepted beat produced no result");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == btpg_pkg::CMD_WRITE) |->
            ##2 (!o_inside_res && o_pixel_color == 16'h0000))
        else $error("write beat returned a pixel");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_busy))
        else $error("result strobe without a beat in flight");

    a_color_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_res) |->
            (o_pixel_color == $past(r_fg_color) ||
             o_pixel_color == $past(r_back_color)))
        else $error("inside pixel is neither foreground nor background");
`endif

endmodule

`default_nettype wire

### tb/tb_bitmap_text_pixel_generator_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_text_pixel_generator_core
// Self-checking bench for the text label pixel generator: command beats and
// register writes go in, every result beat is checked against a shadow render.
// ----------------------------------------------------------------------------

module tb_bitmap_text_pixel_generator_core;

    // Geometry of the block as instantiated (its defaults)
    localparam int MAX_CHARS = 16;
    localparam int CELL_W    = 6;
    localparam int CELL_GAP  = 1;
    localparam int IMG_H     = 16;
    localparam int GLYPH_W   = 5;
    localparam int GLYPH_TOP = (IMG_H - btpg_pkg::GLYPH_ROWS) / 2;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SEG_BEATS     = 50;
    localparam int SEGS_PER_MODE = 7;

    typedef struct packed {
        logic       cmd;
        logic [3:0] slot;
        logic [7:0] code;
        logic [6:0] x;
        logic [4:0] y;
    } t_beat;

    typedef struct packed {
        logic [15:0] color;
        logic        in_img;
        logic [6:0]  width;
        logic        fits;
    } t_pixel;

    localparam int BEAT_W = $bits(t_beat);

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    logic        i_cmd       = btpg_pkg::CMD_WRITE;
    logic [3:0]  i_char_slot = '0;
    logic [7:0]  i_char_code = '0;
    logic [6:0]  i_pixel_x   = '0;
    logic [4:0]  i_pixel_y   = '0;
    logic        o_valid;
    logic [15:0] o_pixel_color;
    logic        o_inside_res;
    logic [6:0]  o_image_width;
    logic        o_fits;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    bitmap_text_pixel_generator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_char_slot   (i_char_slot),
        .i_char_code   (i_char_code),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_valid       (o_valid),
        .o_pixel_color (o_pixel_color),
        .o_inside_res  (o_inside_res),
        .o_image_width (o_image_width),
        .o_fits        (o_fits),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow state: register copies and label store, updated as the DUT's are
    // ------------------------------------------------------------------------
    logic [4:0]  cfg_len = 5'd0;
    logic [15:0] cfg_bg  = 16'h0000;
    logic [15:0] cfg_fg  = 16'hFFFF;
    logic [15:0] cfg_buf = 16'h0000;
    logic [7:0]  label_shadow [MAX_CHARS];

    t_beat  beat_queue   [$];   // beats waiting to be driven
    t_pixel pixel_expect [$];   // predicted result beats, oldest first
    t_beat  beat_on_bus;        // beat currently presented with start high

    int unsigned send_gap_pct    = 0;
    int unsigned mismatch_count  = 0;
    int unsigned results_checked = 0;
    int unsigned writes_taken    = 0;
    int unsigned reads_taken     = 0;
    int unsigned config_writes   = 0;
    int unsigned cycle_count     = 0;

    string glyph_codes = "ACDEHIKMNOPRSTUWacdehikmnoprstuw";

    // 5x7 font: seven row bytes per glyph, top row first, bit 4 = left column
    function automatic logic [55:0] font_rows(input logic [7:0] code, output bit found);
        found = 1'b1;
        case (code)
            8'h41: return 56'h0E11111F111100;   // A
            8'h43: return 56'h0E11101010110E;   // C
            8'h44: return 56'h1E11111111111E;   // D
            8'h45: return 56'h1F10101E10101F;   // E
            8'h48: return 56'h1111111F111111;   // H
            8'h49: return 56'h0E04040404040E;   // I
            8'h4B: return 56'h11121418141211;   // K
            8'h4D: return 56'h111B1511111100;   // M
            8'h4E: return 56'h11191513111100;   // N
            8'h4F: return 56'h0E11111111110E;   // O
            8'h50: return 56'h1F11111F101010;   // P
            8'h52: return 56'h1E11111E141211;   // R
            8'h53: return 56'h0F10100E01011E;   // S
            8'h54: return 56'h1F040404040404;   // T
            8'h55: return 56'h1111111111110E;   // U
            8'h57: return 56'h11111115151B11;   // W
            8'h61: return 56'h00000E010F110F;   // a
            8'h63: return 56'h00000E1010110E;   // c
            8'h64: return 56'h0000010F11110F;   // d
            8'h65: return 56'h00000E111F100E;   // e
            8'h68: return 56'h10101619111111;   // h
            8'h69: return 56'h04000C0404040E;   // i
            8'h6B: return 56'h10101214181412;   // k
            8'h6D: return 56'h00001A15151100;   // m
            8'h6E: return 56'h00001619111111;   // n
            8'h6F: return 56'h00000E1111110E;   // o
            8'h70: return 56'h00001E11111E10;   // p
            8'h72: return 56'h00001619101010;   // r
            8'h73: return 56'h00000E100E011E;   // s
            8'h74: return 56'h04040E04040406;   // t
            8'h75: return 56'h0000111111130D;   // u
            8'h77: return 56'h0000111115150A;   // w
            default: begin
                found = 1'b0;
                return 56'h0;
            end
        endcase
    endfunction

    // Active label length clamps at the store depth
    function automatic int unsigned active_chars(input int unsigned len);
        return (len > MAX_CHARS) ? MAX_CHARS : len;
    endfunction

    function automatic int unsigned label_width(input int unsigned len);
        int unsigned n;
        n = active_chars(len);
        return (n == 0) ? 0 : n * CELL_W - CELL_GAP;
    endfunction

    // Any character whose glyph covers (px,py) with a set bit lights it
    function automatic bit glyph_pixel_set(input int unsigned px, input int unsigned py);
        int unsigned row, col, left;
        logic [55:0] rows;
        logic [7:0]  row_bits;
        bit          found;
        if (py < GLYPH_TOP || py >= GLYPH_TOP + btpg_pkg::GLYPH_ROWS) return 1'b0;
        row = py - GLYPH_TOP;
        for (int k = 0; k < active_chars(32'(cfg_len)); k++) begin
            left = k * CELL_W;
            if (px >= left && px - left < GLYPH_W) begin
                col      = px - left;
                rows     = font_rows(label_shadow[k], found);
                row_bits = rows[8 * (6 - row) +: 8];
                if (found && row_bits[GLYPH_W - 1 - col]) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Result of one accepted beat; a write also updates the shadow store
    function automatic t_pixel render_beat(input t_beat b);
        t_pixel      r;
        int unsigned w, need;
        w        = label_width(32'(cfg_len));
        need     = btpg_pkg::HEADER_BYTES + w * IMG_H * 2;
        r.color  = '0;
        r.in_img = 1'b0;
        if (b.cmd == btpg_pkg::CMD_WRITE) begin
            if (b.slot < MAX_CHARS) label_shadow[b.slot] = b.code;
        end else if (b.x < w && b.y < IMG_H) begin
            r.in_img = 1'b1;
            r.color  = glyph_pixel_set(32'(b.x), 32'(b.y)) ? cfg_fg : cfg_bg;
        end
        r.width = w[6:0];
        r.fits  = (w != 0 && need <= cfg_buf);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch %s: got 0x%0h expected 0x%0h (result #%0d)",
                 what, got, want, results_checked);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Beat builders; unused fields carry random noise
    // ------------------------------------------------------------------------
    function automatic void push_write(input logic [3:0] slot, input logic [7:0] code);
        t_beat b;
        b      = t_beat'(BEAT_W'($urandom));
        b.cmd  = btpg_pkg::CMD_WRITE;
        b.slot = slot;
        b.code = code;
        beat_queue.push_back(b);
    endfunction

    function automatic void push_read(input logic [6:0] x, input logic [4:0] y);
        t_beat b;
        b      = t_beat'(BEAT_W'($urandom));
        b.cmd  = btpg_pkg::CMD_READ;
        b.x    = x;
        b.y    = y;
        beat_queue.push_back(b);
    endfunction

    // Mostly reads aimed at the image and the glyph band, some character
    // rewrites (mostly real glyphs), and a share of anywhere-at-all noise.
    function automatic t_beat random_beat(input int unsigned w);
        t_beat       b;
        int unsigned lim;
        b   = t_beat'(BEAT_W'($urandom));
        lim = (w + 1 > 127) ? 127 : w + 1;
        if ($urandom_range(99) < 20) begin
            b.cmd = btpg_pkg::CMD_WRITE;
            if ($urandom_range(3) != 0) b.code = glyph_codes[$urandom_range(31)];
        end else begin
            b.cmd = btpg_pkg::CMD_READ;
            if ($urandom_range(9) > 2) b.x = 7'($urandom_range(lim));
            case ($urandom_range(3))
                0:       b.y = 5'($urandom);
                1:       b.y = 5'($urandom_range(IMG_H));
                default: b.y = 5'($urandom_range(GLYPH_TOP + btpg_pkg::GLYPH_ROWS,
                                                 GLYPH_TOP - 1));
            endcase
        end
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // Register port: setup then access; pready is waited for in the access
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            btpg_pkg::REG_LABEL_LEN:    cfg_len = value[4:0];
            btpg_pkg::REG_BACK_COLOR:   cfg_bg  = value[15:0];
            btpg_pkg::REG_FG_COLOR:     cfg_fg  = value[15:0];
            btpg_pkg::REG_BUFFER_BYTES: cfg_buf = value[15:0];
            default: ;
        endcase
        config_writes++;
    endtask

    // Wait for an empty pipe, then rewrite all four registers. Upper data
    // bits are random; the block only keeps the field width.
    task automatic program_label(input int unsigned len, input logic [15:0] bg,
                                 input logic [15:0] fg, input int unsigned bufsz);
        logic [31:0] pw;
        while (beat_queue.size() != 0 || start || pixel_expect.size() != 0)
            @(negedge i_clk);
        pw = $urandom; pw[4:0]  = 5'(len);    apb_write(btpg_pkg::REG_LABEL_LEN, pw);
        pw = $urandom; pw[15:0] = bg;         apb_write(btpg_pkg::REG_BACK_COLOR, pw);
        pw = $urandom; pw[15:0] = fg;         apb_write(btpg_pkg::REG_FG_COLOR, pw);
        pw = $urandom; pw[15:0] = 16'(bufsz); apb_write(btpg_pkg::REG_BUFFER_BYTES, pw);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog: %0d cycles, %0d beats unsent, %0d results due",
                     cycle_count, beat_queue.size(), pixel_expect.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: a beat is taken at an edge with start high and busy low. A held
    // beat stays put while busy; otherwise the next beat goes out unless the
    // sender decides to idle this cycle. Prediction happens at the accept.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pixel_expect.push_back(render_beat(beat_on_bus));
                if (beat_on_bus.cmd == btpg_pkg::CMD_WRITE) writes_taken++;
                else reads_taken++;
            end
            if (start && busy) begin
                // held until the block frees up
            end else if (beat_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                beat_on_bus = beat_queue.pop_front();
                start       <= 1'b1;
                i_cmd       <= beat_on_bus.cmd;
                i_char_slot <= beat_on_bus.slot;
                i_char_code <= beat_on_bus.code;
                i_pixel_x   <= beat_on_bus.x;
                i_pixel_y   <= beat_on_bus.y;
            end else begin
                // idle cycle: fields wander while start is low
                start       <= 1'b0;
                i_cmd       <= 1'($urandom);
                i_char_slot <= 4'($urandom);
                i_char_code <= 8'($urandom);
                i_pixel_x   <= 7'($urandom);
                i_pixel_y   <= 5'($urandom);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: a result beat is one cycle wide; sampling mid-cycle keeps it
    // clear of the driver's edge activity.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_monitor
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (pixel_expect.size() == 0) begin
                report_mismatch("result beat with none pending", 32'(o_pixel_color), 0);
            end else begin
                want = pixel_expect.pop_front();
                if (o_pixel_color !== want.color)
                    report_mismatch("pixel_color", 32'(o_pixel_color), 32'(want.color));
                if (o_inside_res !== want.in_img)
                    report_mismatch("inside_res", 32'(o_inside_res), 32'(want.in_img));
                if (o_image_width !== want.width)
                    report_mismatch("image_width", 32'(o_image_width), 32'(want.width));
                if (o_fits !== want.fits)
                    report_mismatch("fits", 32'(o_fits), 32'(want.fits));
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned len, bufsz, need, spins;
        logic [15:0] bg, fg;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty label straight out of reset, then fill every slot
        // so no read can ever touch an entry that was never written.
        send_gap_pct = 29;
        push_read(7'd0, 5'd0);
        push_read(7'd127, 5'd31);
        push_write(4'd0, "A");
        push_write(4'd1, "S");
        push_write(4'd2, 8'hFF);            // no glyph for this code
        push_write(4'd3, "w");
        for (int s = 4; s < 15; s++) push_write(4'(s), glyph_codes[2 * s]);
        push_write(4'd15, 8'h00);

        // "AS?w": 23 columns, buffer exactly the size needed
        program_label(4, 16'h0000, 16'hFFFF, btpg_pkg::HEADER_BYTES + 23 * IMG_H * 2);
        push_read(7'd1, 5'd4);              // A top row, lit
        push_read(7'd5, 5'd6);              // gap column
        push_read(7'd7, 5'd4);              // S top row, lit
        push_read(7'd13, 5'd6);             // unknown code cell
        push_read(7'd21, 5'd10);            // w bottom row, lit
        push_read(7'd0, 5'd3);              // row above the glyph band
        push_read(7'd23, 5'd0);             // first column past the image
        push_read(7'd0, 5'd16);             // first row past the image

        // Random: three sender modes, each over several register settings
        for (int mode = 0; mode < 3; mode++) begin
            send_gap_pct = (mode == 0) ? 29 : (mode == 1) ? 51 : 0;
            for (int seg = 0; seg < SEGS_PER_MODE; seg++) begin
                case ($urandom_range(5))
                    0:       len = 0;
                    1:       len = 1;
                    2:       len = MAX_CHARS;
                    3:       len = $urandom_range(31, MAX_CHARS + 1);
                    default: len = $urandom_range(MAX_CHARS, 1);
                endcase
                bg = 16'($urandom);
                fg = 16'($urandom);
                // extremes of length, colors and buffer size come first
                if (mode == 0 && seg == 0) begin
                    len = 31; bg = 16'hFFFF; fg = 16'h0000;
                end else if (mode == 0 && seg == 1) begin
                    len = MAX_CHARS;
                end else if (mode == 0 && seg == 2) begin
                    len = 0;
                end
                need = btpg_pkg::HEADER_BYTES + label_width(len) * IMG_H * 2;
                case ($urandom_range(5))
                    0:       bufsz = 0;
                    1:       bufsz = 16'hFFFF;
                    2:       bufsz = need;
                    3:       bufsz = need - 1;
                    4:       bufsz = need + $urandom_range(64);
                    default: bufsz = $urandom_range(16'hFFFF);
                endcase
                if (mode == 0 && seg == 0) bufsz = need - 1;    // one byte short
                if (mode == 0 && seg == 1) bufsz = need;
                if (mode == 0 && seg == 2) bufsz = 16'hFFFF;    // empty never fits
                program_label(len, bg, fg, bufsz);
                for (int i = 0; i < SEG_BEATS; i++)
                    beat_queue.push_back(random_beat(label_width(len)));
            end
        end

        // Drain: all beats out, then a bounded wait for the last results
        while (beat_queue.size() != 0 || start) @(negedge i_clk);
        spins = 0;
        while (pixel_expect.size() != 0 && spins < 50) begin
            @(negedge i_clk);
            spins++;
        end
        if (pixel_expect.size() != 0)
            report_mismatch("results never delivered", 0, pixel_expect.size());
        repeat (8) @(posedge i_clk);

        $display("ran %0d character writes and %0d pixel reads under %0d register writes",
                 writes_taken, reads_taken, config_writes);
        $display("checked %0d result beats, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### bitmap_text_pixel_generator_core.f
rtl/core/btpg_pkg.sv
rtl/core/btpg_glyph_tap.sv
rtl/core/bitmap_text_pixel_generator_core.sv
tb/tb_bitmap_text_pixel_generator_core.sv
